[design/dpf_pkg.sv]
// Shared types and constants for the deduplicating packet FIFO.
// No dependencies; used by dpf_cmp, dpf_checker and the core, not by dpf_ram.
package dpf_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int MATCH_W     = 7;
  localparam int CNT_W       = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam int SRC_W       = 16;
  localparam int DST_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int ENTRY_W     = SRC_W + DST_W + STAMP_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(64);
  localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_FWD = 2'd1,
    REQ_CNT = 2'd2
  } req_e;

  typedef struct packed {
    logic [SRC_W-1:0]   src;
    logic [DST_W-1:0]   dst;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic dup;
    logic hit;
  } cmp_res_t;

endpackage

[design/dpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/dpf_cmp.sv]
// Shared compare unit: one stored entry against the request key.
// Depends on dpf_pkg.
module dpf_cmp (
  input  dpf_pkg::entry_t                 entry_i,
  input  dpf_pkg::entry_t                 key_i,
  input  logic [dpf_pkg::STAMP_W-1:0]     lo_i,
  input  logic [dpf_pkg::STAMP_W-1:0]     hi_i,
  output dpf_pkg::cmp_res_t               res_o
);

  logic dst_eq;

  assign dst_eq    = (entry_i.dst == key_i.dst);
  assign res_o.dup = dst_eq && (entry_i.src == key_i.src) && (entry_i.stamp == key_i.stamp);
  assign res_o.hit = dst_eq && (entry_i.stamp >= lo_i) && (entry_i.stamp <= hi_i);

endmodule

[design/dedup_packet_fifo_with_range_count_core.sv]
// Top level of the deduplicating packet FIFO with range count.
// Depends on dpf_pkg, dpf_ram and dpf_cmp.
//
// Requests arrive on the in channel (valid/ready); each yields exactly one
// result transfer on the out channel. The queue_limit register is written
// through the cfg channel, which is always ready; write it only while idle.
// Add and count walk the queued entries through one shared compare unit,
// one entry per cycle, reading the entry RAM in a pipelined fashion.
// Add and count pass through the scan state when the queue is not empty;
// otherwise, and for forward and unknown requests, the sequencer goes
// straight to the finish state. The input is not ready again until the
// result is loaded into the output register, so no new request is taken
// before the last one has its result loaded. A held result does not block the next
// input transfer; the next result waits in the sequencer until the output
// register frees up.
// Reset empties the queue and sets queue_limit to 64; entry storage is not
// cleared, as only occupied slots are ever read.
module dedup_packet_fifo_with_range_count_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [dpf_pkg::SRC_W-1:0]     src_id_i,
  input  logic [dpf_pkg::DST_W-1:0]     dst_id_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   stamp_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   range_start_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   range_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          added_o,
  output logic                          fwd_valid_o,
  output logic [dpf_pkg::SRC_W-1:0]     fwd_src_o,
  output logic [dpf_pkg::DST_W-1:0]     fwd_dst_o,
  output logic [dpf_pkg::STAMP_W-1:0]   fwd_stamp_o,
  output logic [dpf_pkg::MATCH_W-1:0]   match_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dpf_pkg::LIMIT_W-1:0]   cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  function automatic logic [dpf_pkg::PTR_W-1:0] next_slot(
    input logic [dpf_pkg::PTR_W-1:0] p
  );
    logic [dpf_pkg::PTR_W-1:0] r;
    if (p == dpf_pkg::PTR_W'(dpf_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  state_e                       state_q, state_d;
  logic [1:0]                   req_q, req_d;
  dpf_pkg::entry_t              key_q, key_d;
  logic [dpf_pkg::STAMP_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [dpf_pkg::PTR_W-1:0]    head_q, head_d, tail_q, tail_d, scan_ptr_q, scan_ptr_d;
  logic [dpf_pkg::OCC_W-1:0]    occ_q, occ_d, iss_q, iss_d;
  logic [dpf_pkg::LIMIT_W-1:0]  limit_q, limit_d;
  logic                         cmp_vld_q, cmp_vld_d, dup_q, dup_d;
  logic [dpf_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  logic                         out_valid_q, out_valid_d, added_q, added_d;
  logic                         fwd_valid_q, fwd_valid_d;
  dpf_pkg::entry_t              fwd_q, fwd_d;
  logic [dpf_pkg::MATCH_W-1:0]  match_q, match_d;

  logic [dpf_pkg::ENTRY_W-1:0]  ram_rdata;
  dpf_pkg::entry_t              rd_entry;
  logic [dpf_pkg::PTR_W-1:0]    ram_raddr;
  logic                         ram_we;
  dpf_pkg::cmp_res_t            cmp_res;
  logic                         slot_free, issue, full;
  logic [dpf_pkg::CNT_W-1:0]    lim_ext, eff_lim;

  assign rd_entry  = dpf_pkg::entry_t'(ram_rdata);
  assign ram_raddr = (state_q == ST_SCAN) ? scan_ptr_q : head_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign issue     = (iss_q != occ_q);
  assign ram_we    = (state_q == ST_FINISH) && slot_free && (req_q == dpf_pkg::REQ_ADD) && !dup_q;

  always_comb begin
    lim_ext = dpf_pkg::CNT_W'(limit_q);
    if (lim_ext == '0) begin
      eff_lim = dpf_pkg::CNT_W'(1);
    end else if (lim_ext > dpf_pkg::CNT_W'(dpf_pkg::QUEUE_DEPTH)) begin
      eff_lim = dpf_pkg::CNT_W'(dpf_pkg::QUEUE_DEPTH);
    end else begin
      eff_lim = lim_ext;
    end
    full = (dpf_pkg::CNT_W'(occ_q) >= eff_lim);
  end

  dpf_ram #(
    .WIDTH(dpf_pkg::ENTRY_W),
    .DEPTH(dpf_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(key_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  dpf_cmp u_cmp (
    .entry_i(rd_entry),
    .key_i  (key_q),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .res_o  (cmp_res)
  );

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign added_o       = added_q;
  assign fwd_valid_o   = fwd_valid_q;
  assign fwd_src_o     = fwd_q.src;
  assign fwd_dst_o     = fwd_q.dst;
  assign fwd_stamp_o   = fwd_q.stamp;
  assign match_count_o = match_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    scan_ptr_d  = scan_ptr_q;
    iss_d       = iss_q;
    cmp_vld_d   = cmp_vld_q;
    dup_d       = dup_q;
    cnt_d       = cnt_q;
    limit_d     = cfg_valid_i ? cfg_data_i : limit_q;
    out_valid_d = out_valid_q;
    added_d     = added_q;
    fwd_valid_d = fwd_valid_q;
    fwd_d       = fwd_q;
    match_d     = match_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d       = req_type_i;
          key_d.src   = src_id_i;
          key_d.dst   = dst_id_i;
          key_d.stamp = stamp_i;
          lo_d        = range_start_i;
          hi_d        = range_end_i;
          scan_ptr_d  = head_q;
          iss_d       = '0;
          cmp_vld_d   = 1'b0;
          dup_d       = 1'b0;
          cnt_d       = '0;
          if ((req_type_i == dpf_pkg::REQ_ADD || req_type_i == dpf_pkg::REQ_CNT)
              && occ_q != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmp_vld_d = issue;
        if (issue) begin
          scan_ptr_d = next_slot(scan_ptr_q);
          iss_d      = iss_q + 1'b1;
        end
        if (cmp_vld_q) begin
          dup_d = dup_q | cmp_res.dup;
          if (cmp_res.hit) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (!issue && !cmp_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          added_d     = 1'b0;
          fwd_valid_d = 1'b0;
          fwd_d       = '0;
          match_d     = '0;
          case (req_q)
            dpf_pkg::REQ_ADD: begin
              if (!dup_q) begin
                added_d = 1'b1;
                tail_d  = next_slot(tail_q);
                if (full) begin
                  head_d = next_slot(head_q);
                end else begin
                  occ_d = occ_q + 1'b1;
                end
              end
            end
            dpf_pkg::REQ_FWD: begin
              if (occ_q != '0) begin
                fwd_valid_d = 1'b1;
                fwd_d       = rd_entry;
                head_d      = next_slot(head_q);
                occ_d       = occ_q - 1'b1;
              end
            end
            dpf_pkg::REQ_CNT: begin
              if (cnt_q > dpf_pkg::CNT_W'(dpf_pkg::MATCH_MAX)) begin
                match_d = dpf_pkg::MATCH_MAX;
              end else begin
                match_d = cnt_q[dpf_pkg::MATCH_W-1:0];
              end
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      key_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      scan_ptr_q  <= '0;
      iss_q       <= '0;
      cmp_vld_q   <= 1'b0;
      dup_q       <= 1'b0;
      cnt_q       <= '0;
      limit_q     <= dpf_pkg::LIMIT_RST;
      out_valid_q <= 1'b0;
      added_q     <= 1'b0;
      fwd_valid_q <= 1'b0;
      fwd_q       <= '0;
      match_q     <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      key_q       <= key_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      scan_ptr_q  <= scan_ptr_d;
      iss_q       <= iss_d;
      cmp_vld_q   <= cmp_vld_d;
      dup_q       <= dup_d;
      cnt_q       <= cnt_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      added_q     <= added_d;
      fwd_valid_q <= fwd_valid_d;
      fwd_q       <= fwd_d;
      match_q     <= match_d;
    end
  end

endmodule

[design/dpf_checker.sv]
// Port-level assertions for the deduplicating packet FIFO, with bind.
// Depends on dpf_pkg and dedup_packet_fifo_with_range_count_core.
module dpf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          added_o,
  input logic                          fwd_valid_o,
  input logic [dpf_pkg::SRC_W-1:0]     fwd_src_o,
  input logic [dpf_pkg::DST_W-1:0]     fwd_dst_o,
  input logic [dpf_pkg::STAMP_W-1:0]   fwd_stamp_o,
  input logic [dpf_pkg::MATCH_W-1:0]   match_count_o
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(added_o) && $stable(fwd_valid_o)
      && $stable(fwd_stamp_o) && $stable(match_count_o))
    else $error("result changed while stalled");

  // not ready straight after a request transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready straight after request transfer");

  a_fwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fwd_valid_o |-> fwd_src_o == '0 && fwd_dst_o == '0 && fwd_stamp_o == '0)
    else $error("forward fields set without forward");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(added_o && fwd_valid_o) && !(added_o && match_count_o != '0)
      && !(fwd_valid_o && match_count_o != '0))
    else $error("result mixes request kinds");

endmodule

bind dedup_packet_fifo_with_range_count_core dpf_checker u_dpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .added_o      (added_o),
  .fwd_valid_o  (fwd_valid_o),
  .fwd_src_o    (fwd_src_o),
  .fwd_dst_o    (fwd_dst_o),
  .fwd_stamp_o  (fwd_stamp_o),
  .match_count_o(match_count_o)
);

[verif/dpf_queue_checker.sv]
// Checker for the deduplicating packet FIFO: watches the request, result and
// limit channels, keeps its own copy of the queue and compares every result.
// Depends on dpf_pkg.
module dpf_queue_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    req_type_i,
  input  logic [dpf_pkg::SRC_W-1:0]     src_id_i,
  input  logic [dpf_pkg::DST_W-1:0]     dst_id_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   stamp_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   range_start_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   range_end_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          added_i,
  input  logic                          fwd_valid_i,
  input  logic [dpf_pkg::SRC_W-1:0]     fwd_src_i,
  input  logic [dpf_pkg::DST_W-1:0]     fwd_dst_i,
  input  logic [dpf_pkg::STAMP_W-1:0]   fwd_stamp_i,
  input  logic [dpf_pkg::MATCH_W-1:0]   match_count_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [dpf_pkg::LIMIT_W-1:0]   cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpf_pkg::*;

  typedef struct packed {
    logic               added;
    logic               fwd_valid;
    logic [SRC_W-1:0]   src;
    logic [DST_W-1:0]   dst;
    logic [STAMP_W-1:0] stamp;
    logic [MATCH_W-1:0] hits;
  } outcome_t;

  entry_t             slots [QUEUE_DEPTH];
  int                 oldest_slot;
  int                 free_slot;
  int                 queued;
  logic [LIMIT_W-1:0] limit_reg;
  outcome_t           expected_q [$];
  outcome_t           want;
  int                 errors = 0;

  function automatic outcome_t serve_request(
    input logic [1:0]         req,
    input logic [SRC_W-1:0]   s,
    input logic [DST_W-1:0]   d,
    input logic [STAMP_W-1:0] st,
    input logic [STAMP_W-1:0] lo,
    input logic [STAMP_W-1:0] hi
  );
    outcome_t res;
    entry_t   incoming;
    int       p;
    int       cap;
    int       hits;
    logic     dup;
    res = '0;
    incoming = '{src: s, dst: d, stamp: st};
    p = oldest_slot;
    hits = 0;
    dup = 1'b0;
    if (limit_reg == 0) cap = 1;
    else if (limit_reg > QUEUE_DEPTH) cap = QUEUE_DEPTH;
    else cap = int'(limit_reg);
    case (req)
      REQ_ADD: begin
        for (int i = 0; i < queued; i++) begin
          if (slots[p] == incoming) dup = 1'b1;
          p = (p + 1) % QUEUE_DEPTH;
        end
        if (!dup) begin
          // full: the oldest one goes silently, even when the limit was lowered
          if (queued >= cap) begin
            oldest_slot = (oldest_slot + 1) % QUEUE_DEPTH;
            queued--;
          end
          slots[free_slot] = incoming;
          free_slot = (free_slot + 1) % QUEUE_DEPTH;
          queued++;
          res.added = 1'b1;
        end
      end
      REQ_FWD: begin
        if (queued > 0) begin
          res.fwd_valid = 1'b1;
          res.src = slots[oldest_slot].src;
          res.dst = slots[oldest_slot].dst;
          res.stamp = slots[oldest_slot].stamp;
          oldest_slot = (oldest_slot + 1) % QUEUE_DEPTH;
          queued--;
        end
      end
      REQ_CNT: begin
        for (int i = 0; i < queued; i++) begin
          if (slots[p].dst == d && slots[p].stamp >= lo && slots[p].stamp <= hi) hits++;
          p = (p + 1) % QUEUE_DEPTH;
        end
        res.hits = (hits > int'(MATCH_MAX)) ? MATCH_MAX : MATCH_W'(hits);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_slot = 0;
      free_slot = 0;
      queued = 0;
      limit_reg = LIMIT_RST;
      expected_q.delete();
      pending_o <= 0;
      fail_count_o <= errors;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          $error("result transfer with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("added", 32'(want.added), 32'(added_i));
          check_field("fwd_valid", 32'(want.fwd_valid), 32'(fwd_valid_i));
          check_field("fwd_src", 32'(want.src), 32'(fwd_src_i));
          check_field("fwd_dst", 32'(want.dst), 32'(fwd_dst_i));
          check_field("fwd_stamp", want.stamp, fwd_stamp_i);
          check_field("match_count", 32'(want.hits), 32'(match_count_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_reg = cfg_data_i;
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(),
                          serve_request(req_type_i, src_id_i, dst_id_i, stamp_i,
                                        range_start_i, range_end_i));
      pending_o <= expected_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

[verif/dedup_packet_fifo_with_range_count_core_tb.sv]
// Testbench top for dedup_packet_fifo_with_range_count_core: drives requests,
// limit writes and result back-pressure, and reports the verdict.
// Depends on dpf_pkg, dpf_queue_checker and the design.
module dedup_packet_fifo_with_range_count_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpf_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 175;
  localparam int TAIL_ITEMS = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_kind = REQ_FWD;
  logic [SRC_W-1:0]   pkt_src = '0;
  logic [DST_W-1:0]   pkt_dst = '0;
  logic [STAMP_W-1:0] pkt_stamp = '0;
  logic [STAMP_W-1:0] win_lo = '0;
  logic [STAMP_W-1:0] win_hi = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               added;
  logic               fwd_valid;
  logic [SRC_W-1:0]   fwd_src;
  logic [DST_W-1:0]   fwd_dst;
  logic [STAMP_W-1:0] fwd_stamp;
  logic [MATCH_W-1:0] match_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  int                 pending;
  int                 fail_count;
  int                 gap_level = 0;
  int                 stall_level = 0;
  bit                 hold_pending = 1'b0;
  entry_t             sent_pkts [$];

  always #2 clk = ~clk;

  dedup_packet_fifo_with_range_count_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_kind),
    .src_id_i      (pkt_src),
    .dst_id_i      (pkt_dst),
    .stamp_i       (pkt_stamp),
    .range_start_i (win_lo),
    .range_end_i   (win_hi),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .added_o       (added),
    .fwd_valid_o   (fwd_valid),
    .fwd_src_o     (fwd_src),
    .fwd_dst_o     (fwd_dst),
    .fwd_stamp_o   (fwd_stamp),
    .match_count_o (match_count),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  dpf_queue_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .req_type_i    (req_kind),
    .src_id_i      (pkt_src),
    .dst_id_i      (pkt_dst),
    .stamp_i       (pkt_stamp),
    .range_start_i (win_lo),
    .range_end_i   (win_hi),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .added_i       (added),
    .fwd_valid_i   (fwd_valid),
    .fwd_src_i     (fwd_src),
    .fwd_dst_i     (fwd_dst),
    .fwd_stamp_i   (fwd_stamp),
    .match_count_i (match_count),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // valid stays high between back-to-back transfers
  task automatic offer(input logic [1:0] kind, input logic [SRC_W-1:0] s,
                       input logic [DST_W-1:0] d, input logic [STAMP_W-1:0] st,
                       input logic [STAMP_W-1:0] lo, input logic [STAMP_W-1:0] hi);
    if (gap_level != 0 && $urandom_range(0, 15) < gap_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_kind <= kind;
    pkt_src <= s;
    pkt_dst <= d;
    pkt_stamp <= st;
    win_lo <= lo;
    win_hi <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // small alphabets so that duplicates and count hits are common
  function automatic logic [15:0] rand_id();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] rand_stamp();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom;
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return 32'($urandom_range(0, 15));
  endfunction

  task automatic offer_random();
    int                 pick;
    logic [1:0]         kind;
    entry_t             pkt;
    logic [STAMP_W-1:0] lo;
    logic [STAMP_W-1:0] hi;
    logic [STAMP_W-1:0] tmp;
    pick = $urandom_range(0, 99);
    if (pick < 45) kind = REQ_ADD;
    else if (pick < 67) kind = REQ_FWD;
    else if (pick < 95) kind = REQ_CNT;
    else kind = REQ_BAD;
    if (kind == REQ_ADD && sent_pkts.size() != 0 && $urandom_range(0, 9) < 3) begin
      pkt = sent_pkts[$urandom_range(0, sent_pkts.size() - 1)];
    end else begin
      pkt.src = rand_id();
      pkt.dst = rand_id();
      pkt.stamp = rand_stamp();
    end
    lo = rand_stamp();
    hi = rand_stamp();
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    if ($urandom_range(0, 9) == 0) begin
      lo = '0;
      hi = '1;
    end
    if (kind == REQ_ADD) begin
      sent_pkts.insert(sent_pkts.size(), pkt);
      if (sent_pkts.size() > 32) void'(sent_pkts.pop_front());
    end
    offer(kind, pkt.src, pkt.dst, pkt.stamp, lo, hi);
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else if (stall_level != 0 && $urandom_range(0, 15) < stall_level) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] limits [9];
    limits = '{7'd127, 7'd64, 7'd2, 7'd5, 7'd17, 7'd0, 7'd33, 7'd1, 7'd100};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, unknown type, field extremes, duplicates, windows
    offer(REQ_FWD, '0, '0, '0, '0, '0);
    offer(REQ_CNT, '0, '0, '0, '0, '1);
    offer(REQ_BAD, '1, '1, '1, '1, '1);
    offer(REQ_ADD, '1, '1, '1, '0, '0);
    offer(REQ_ADD, '0, '0, '0, '1, '1);
    offer(REQ_ADD, '1, '1, '1, '0, '0);
    offer(REQ_CNT, '0, '1, '0, '0, '1);
    offer(REQ_CNT, '0, '1, '0, '1, '0);
    offer(REQ_CNT, '0, '1, '0, '1, '1);
    offer(REQ_FWD, '0, '0, '0, '0, '0);
    offer(REQ_FWD, '0, '0, '0, '0, '0);
    offer(REQ_FWD, '0, '0, '0, '0, '0);

    // limit of one: eviction, and a duplicate of the oldest entry when full
    set_limit(7'd1);
    offer(REQ_ADD, 16'd1, 16'd2, 32'd3, '0, '0);
    offer(REQ_ADD, 16'd4, 16'd5, 32'd6, '0, '0);
    offer(REQ_ADD, 16'd4, 16'd5, 32'd6, '0, '0);
    offer(REQ_FWD, '0, '0, '0, '0, '0);

    // zero acts as one
    set_limit(7'd0);
    offer(REQ_ADD, 16'd7, 16'd7, 32'd7, '0, '0);
    offer(REQ_ADD, 16'd8, 16'd8, 32'd8, '0, '0);

    // limit lowered below occupancy
    set_limit(7'd3);
    offer(REQ_ADD, 16'd9, 16'd9, 32'd9, '0, '0);
    offer(REQ_ADD, 16'd10, 16'd10, 32'd10, '0, '0);
    set_limit(7'd1);
    offer(REQ_ADD, 16'd11, 16'd11, 32'd11, '0, '0);
    offer(REQ_CNT, '0, 16'd10, '0, '0, '1);
    offer(REQ_FWD, '0, '0, '0, '0, '0);

    foreach (limits[i]) begin
      set_limit(limits[i]);
      if (i == 1) begin
        gap_level = 0;
        stall_level = 0;
      end else begin
        gap_level = $urandom_range(1, 6);
        stall_level = $urandom_range(1, 6);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (i == 2 && n == 20) begin
          gap_level = 0;
          hold_pending = 1'b1;
        end
        offer_random();
      end
    end

    set_limit(7'd64);
    gap_level = 0;
    stall_level = 0;
    repeat (TAIL_ITEMS) offer_random();

    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
